// File: sv/yrzpc_pkg.sv
// ---------------------------------------------------------------------------
// yrzpc_pkg
// Shared types, register indexes and zone bound arithmetic for the YUV
// range zone pixel counter.
// ---------------------------------------------------------------------------
package yrzpc_pkg;

   localparam int PIX_W    = 8;
   localparam int COUNT_W  = 16;
   localparam int COL_W    = 11;
   localparam int ROW_W    = 12;
   localparam int WP_W     = 12;
   localparam int HT_W     = 13;
   localparam int CSR_W    = 13;
   localparam int MAX_SCAN = 4096;

   localparam logic [WP_W-1:0]    MAX_WIDTH_PAIRS = 12'd2048;
   localparam logic [HT_W-1:0]    MAX_HEIGHT      = 13'd4096;
   localparam logic [COUNT_W-1:0] COUNT_MAX       = 16'hFFFF;

   // Reciprocal of ten: floor(x/10) == (x * 52429) >> 19 for x below 43690
   localparam logic [30:0] RECIP_TEN = 31'd52429;

   typedef enum logic [2:0] {
      CSR_LUMA_LOW   = 3'd0,
      CSR_LUMA_HIGH  = 3'd1,
      CSR_CB_LOW     = 3'd2,
      CSR_CB_HIGH    = 3'd3,
      CSR_CR_LOW     = 3'd4,
      CSR_CR_HIGH    = 3'd5,
      CSR_WIDTH      = 3'd6,
      CSR_HEIGHT     = 3'd7
   } csr_index_type;

   typedef struct packed {
      logic [ROW_W-1:0] row_last;
      logic [ROW_W-1:0] left_stop;
      logic [ROW_W-1:0] mid_first;
      logic [ROW_W-1:0] mid_stop;
      logic [ROW_W-1:0] right_first;
   } zone_bounds_type;

   // h is the clamped height, 1 to 4096
   function automatic zone_bounds_type zone_bounds(input logic [HT_W-1:0] h);
      logic [14:0]     h3;
      logic [14:0]     h7;
      logic [30:0]     p3;
      logic [30:0]     p7;
      zone_bounds_type b;
      h3 = 15'(h) * 15'd3;
      h7 = 15'(h) * 15'd7;
      p3 = 31'(h3) * RECIP_TEN;
      p7 = 31'(h7) * RECIP_TEN;
      b.row_last    = ROW_W'(h - 13'd1);
      b.left_stop   = p3[30:19];
      b.mid_first   = ROW_W'(h >> 2);
      b.mid_stop    = h3[13:2];
      b.right_first = p7[30:19];
      return b;
   endfunction

   function automatic logic [COUNT_W-1:0] sat_add(input logic [COUNT_W-1:0] v,
                                                  input logic [1:0]         n);
      logic [COUNT_W:0] s;
      s = {1'b0, v} + (COUNT_W+1)'(n);
      return s[COUNT_W] ? COUNT_MAX : s[COUNT_W-1:0];
   endfunction

endpackage

// File: sv/yuv_range_zone_pixel_count.sv
// ---------------------------------------------------------------------------
// yuv_range_zone_pixel_count
// Counts YUV422 pixels that fall in a configured color box, sampled in
// vertical strips, into a frame total and three overlapping row zones.
// ---------------------------------------------------------------------------
// One pixel pair (U, Y0, V, Y1) is taken every clock cycle while req_valid and
// req_ready are high; the pair is classified and the counters advance in the
// cycle it is accepted. The column and row are tracked internally from
// width_pairs and image_height. After the last pair of a frame the four
// saturating counts land in the response register in the next cycle and wait
// there; while a response waits and rsp_ready is low, req_ready is low and
// requests stall. Zone bounds are computed when image_height is written, so
// program the registers between frames only.
module yuv_range_zone_pixel_count #(
   parameter int STRIP_COUNT     = 5,
   parameter int STRIP_THICKNESS = 1,
   parameter int STRIP_GAP       = 15
) (
   input  logic                           clock,
   input  logic                           reset,

   input  logic                           req_valid,
   output logic                           req_ready,
   input  logic                           req_start_of_frame,
   input  logic [yrzpc_pkg::PIX_W-1:0]    req_cb_sample,
   input  logic [yrzpc_pkg::PIX_W-1:0]    req_luma_even,
   input  logic [yrzpc_pkg::PIX_W-1:0]    req_cr_sample,
   input  logic [yrzpc_pkg::PIX_W-1:0]    req_luma_odd,

   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output logic [yrzpc_pkg::COUNT_W-1:0]  rsp_total_count,
   output logic [yrzpc_pkg::COUNT_W-1:0]  rsp_left_count,
   output logic [yrzpc_pkg::COUNT_W-1:0]  rsp_center_count,
   output logic [yrzpc_pkg::COUNT_W-1:0]  rsp_right_count,

   input  logic                           csr_wr_en,
   input  logic [2:0]                     csr_index,
   input  logic [yrzpc_pkg::CSR_W-1:0]    csr_wdata
);

   localparam int BLOCK = STRIP_THICKNESS + STRIP_GAP;
   localparam int SPAN  = BLOCK * STRIP_COUNT - STRIP_GAP;
   localparam int POS_W = $clog2(yrzpc_pkg::MAX_SCAN + STRIP_COUNT * BLOCK
                                 + STRIP_THICKNESS) + 1;
   localparam int PIX_W   = yrzpc_pkg::PIX_W;
   localparam int COUNT_W = yrzpc_pkg::COUNT_W;
   localparam int COL_W   = yrzpc_pkg::COL_W;
   localparam int ROW_W   = yrzpc_pkg::ROW_W;

   // configuration
   logic [PIX_W-1:0]           luma_low_ff, luma_high_ff;
   logic [PIX_W-1:0]           cb_low_ff, cb_high_ff;
   logic [PIX_W-1:0]           cr_low_ff, cr_high_ff;
   logic [COL_W-1:0]           col_last_ff;
   yrzpc_pkg::zone_bounds_type bounds_ff;

   logic [yrzpc_pkg::WP_W-1:0] wp_raw;
   logic [yrzpc_pkg::WP_W-1:0] wp_eff;
   logic [yrzpc_pkg::HT_W-1:0] ht_raw;
   logic [yrzpc_pkg::HT_W-1:0] ht_eff;

   // position and tallies
   logic [COL_W-1:0]   col_ff, col_in;
   logic [ROW_W-1:0]   row_ff, row_in;
   logic [COUNT_W-1:0] total_ff, total_in;
   logic [COUNT_W-1:0] left_ff, left_in;
   logic [COUNT_W-1:0] center_ff, center_in;
   logic [COUNT_W-1:0] right_ff, right_in;

   logic               rsp_valid_ff, rsp_valid_in;
   logic [COUNT_W-1:0] rsp_total_ff, rsp_left_ff, rsp_center_ff, rsp_right_ff;

   logic               accept;
   logic               frame_done;
   logic [COL_W-1:0]   col_cur;
   logic [ROW_W-1:0]   row_cur;
   logic [COUNT_W-1:0] total_base, left_base, center_base, right_base;
   logic [POS_W-1:0]   scan_w;
   logic [POS_W-1:0]   offset;
   logic [POS_W-1:0]   x_even, x_odd;
   logic               samp_even, samp_odd;
   logic               chroma_ok;
   logic               hit_even, hit_odd;
   logic [1:0]         hits;
   logic               in_left, in_center, in_right;

   assign wp_raw = csr_wdata[yrzpc_pkg::WP_W-1:0];
   assign wp_eff = (wp_raw == '0) ? yrzpc_pkg::WP_W'(1) :
                   (wp_raw > yrzpc_pkg::MAX_WIDTH_PAIRS) ? yrzpc_pkg::MAX_WIDTH_PAIRS :
                   wp_raw;
   assign ht_raw = csr_wdata[yrzpc_pkg::HT_W-1:0];
   assign ht_eff = (ht_raw == '0) ? yrzpc_pkg::HT_W'(1) :
                   (ht_raw > yrzpc_pkg::MAX_HEIGHT) ? yrzpc_pkg::MAX_HEIGHT : ht_raw;

   always_ff @(posedge clock) begin
      if (reset) begin
         luma_low_ff  <= '0;
         luma_high_ff <= '1;
         cb_low_ff    <= '0;
         cb_high_ff   <= '1;
         cr_low_ff    <= '0;
         cr_high_ff   <= '1;
         col_last_ff  <= COL_W'(119);
         bounds_ff    <= yrzpc_pkg::zone_bounds(yrzpc_pkg::HT_W'(240));
      end else if (csr_wr_en) begin
         unique case (yrzpc_pkg::csr_index_type'(csr_index))
            yrzpc_pkg::CSR_LUMA_LOW:  luma_low_ff  <= csr_wdata[PIX_W-1:0];
            yrzpc_pkg::CSR_LUMA_HIGH: luma_high_ff <= csr_wdata[PIX_W-1:0];
            yrzpc_pkg::CSR_CB_LOW:    cb_low_ff    <= csr_wdata[PIX_W-1:0];
            yrzpc_pkg::CSR_CB_HIGH:   cb_high_ff   <= csr_wdata[PIX_W-1:0];
            yrzpc_pkg::CSR_CR_LOW:    cr_low_ff    <= csr_wdata[PIX_W-1:0];
            yrzpc_pkg::CSR_CR_HIGH:   cr_high_ff   <= csr_wdata[PIX_W-1:0];
            yrzpc_pkg::CSR_WIDTH:     col_last_ff  <= COL_W'(wp_eff - 12'd1);
            yrzpc_pkg::CSR_HEIGHT:    bounds_ff    <= yrzpc_pkg::zone_bounds(ht_eff);
            default: ;
         endcase
      end
   end

   // handshake: the response register decouples the two sides
   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign accept    = req_valid && req_ready;

   // clamp position against the current size, clear on start of frame
   always_comb begin
      col_cur     = (col_ff > col_last_ff) ? col_last_ff : col_ff;
      row_cur     = (row_ff > bounds_ff.row_last) ? bounds_ff.row_last : row_ff;
      total_base  = total_ff;
      left_base   = left_ff;
      center_base = center_ff;
      right_base  = right_ff;
      if (req_start_of_frame) begin
         col_cur     = '0;
         row_cur     = '0;
         total_base  = '0;
         left_base   = '0;
         center_base = '0;
         right_base  = '0;
      end
   end

   // strip sampling
   assign scan_w = POS_W'({col_last_ff, 1'b1}) + POS_W'(1);
   assign offset = (scan_w > POS_W'(SPAN)) ? ((scan_w - POS_W'(SPAN)) >> 1) : '0;
   assign x_even = POS_W'({col_cur, 1'b0});
   assign x_odd  = POS_W'({col_cur, 1'b1});

   always_comb begin
      logic [POS_W-1:0] start;
      samp_even = 1'b0;
      samp_odd  = 1'b0;
      for (int i = 0; i < STRIP_COUNT; i++) begin
         start = offset + POS_W'(i * BLOCK);
         if (x_even >= start && x_even < start + POS_W'(STRIP_THICKNESS)) begin
            samp_even = 1'b1;
         end
         if (x_odd >= start && x_odd < start + POS_W'(STRIP_THICKNESS)) begin
            samp_odd = 1'b1;
         end
      end
   end

   assign chroma_ok = (req_cb_sample >= cb_low_ff) && (req_cb_sample <= cb_high_ff) &&
                      (req_cr_sample >= cr_low_ff) && (req_cr_sample <= cr_high_ff);
   assign hit_even  = samp_even && chroma_ok &&
                      (req_luma_even >= luma_low_ff) && (req_luma_even <= luma_high_ff);
   assign hit_odd   = samp_odd && chroma_ok &&
                      (req_luma_odd >= luma_low_ff) && (req_luma_odd <= luma_high_ff);
   assign hits      = 2'(hit_even) + 2'(hit_odd);

   assign in_left   = row_cur < bounds_ff.left_stop;
   assign in_center = (row_cur >= bounds_ff.mid_first) &&
                      (row_cur < bounds_ff.mid_stop);
   assign in_right  = row_cur >= bounds_ff.right_first;

   assign frame_done = (col_cur == col_last_ff) && (row_cur == bounds_ff.row_last);

   always_comb begin
      total_in  = yrzpc_pkg::sat_add(total_base, hits);
      left_in   = in_left   ? yrzpc_pkg::sat_add(left_base, hits)   : left_base;
      center_in = in_center ? yrzpc_pkg::sat_add(center_base, hits) : center_base;
      right_in  = in_right  ? yrzpc_pkg::sat_add(right_base, hits)  : right_base;
      col_in    = col_cur + COL_W'(1);
      row_in    = row_cur;
      if (col_cur == col_last_ff) begin
         col_in = '0;
         row_in = row_cur + ROW_W'(1);
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      if (accept && frame_done) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff       <= '0;
         row_ff       <= '0;
         total_ff     <= '0;
         left_ff      <= '0;
         center_ff    <= '0;
         right_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (accept) begin
            if (frame_done) begin
               // wrap to a fresh frame
               col_ff    <= '0;
               row_ff    <= '0;
               total_ff  <= '0;
               left_ff   <= '0;
               center_ff <= '0;
               right_ff  <= '0;
            end else begin
               col_ff    <= col_in;
               row_ff    <= row_in;
               total_ff  <= total_in;
               left_ff   <= left_in;
               center_ff <= center_in;
               right_ff  <= right_in;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept && frame_done) begin
         rsp_total_ff  <= total_in;
         rsp_left_ff   <= left_in;
         rsp_center_ff <= center_in;
         rsp_right_ff  <= right_in;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_total_count  = rsp_total_ff;
   assign rsp_left_count   = rsp_left_ff;
   assign rsp_center_count = rsp_center_ff;
   assign rsp_right_count  = rsp_right_ff;

endmodule

// File: bench/yuv_range_zone_pixel_count_test.sv
// ---------------------------------------------------------------------------
// yuv_range_zone_pixel_count_test
// Self-checking bench for the YUV range zone pixel counter. A scripted set of
// pixel pair requests and register writes covers reset values, range bounds,
// inverted ranges, a zone frame and a mid-frame size change. Frames opened at
// out-of-range sizes follow, each closed by a shrink to one pair, then
// randomized settings and frames with random gaps on both channels. Every
// frame result is compared field by field against a cycle-free model of the
// counter kept in the bench.
// ---------------------------------------------------------------------------
module yuv_range_zone_pixel_count_test;

   localparam int PIX_W   = yrzpc_pkg::PIX_W;
   localparam int COUNT_W = yrzpc_pkg::COUNT_W;
   localparam int CSR_W   = yrzpc_pkg::CSR_W;
   localparam int WP_W    = yrzpc_pkg::WP_W;
   localparam int HT_W    = yrzpc_pkg::HT_W;
   localparam int COL_W   = yrzpc_pkg::COL_W;
   localparam int ROW_W   = yrzpc_pkg::ROW_W;

   localparam int STRIPS        = 5;
   localparam int STRIP_WIDTH   = 1;
   localparam int STRIP_SPACING = 15;
   localparam int PAIR_BUDGET   = 850;
   localparam int CLAMP_PAIRS   = 20;
   localparam int HOLD_CYCLES   = 400;
   localparam int MAX_GAP       = 19;
   localparam int SETTLE_CYCLES = 4;

   typedef struct packed {
      logic             sof;
      logic [PIX_W-1:0] cb;
      logic [PIX_W-1:0] y_even;
      logic [PIX_W-1:0] cr;
      logic [PIX_W-1:0] y_odd;
   } pair_type;

   typedef struct packed {
      logic [COUNT_W-1:0] total;
      logic [COUNT_W-1:0] left_zone;
      logic [COUNT_W-1:0] center_zone;
      logic [COUNT_W-1:0] right_zone;
   } counts_type;

   typedef enum logic { ROW_PAIR, ROW_CSR } row_kind_type;

   typedef struct {
      row_kind_type             kind;
      yrzpc_pkg::csr_index_type idx;
      logic [CSR_W-1:0]         value;
      pair_type                 pair;
      bit                       typed;
      counts_type               counts;
   } script_row_type;

   logic               clock              = 1'b0;
   logic               reset              = 1'b1;
   logic               req_valid          = 1'b0;
   logic               req_ready;
   logic               req_start_of_frame = 1'b0;
   logic [PIX_W-1:0]   req_cb_sample      = '0;
   logic [PIX_W-1:0]   req_luma_even      = '0;
   logic [PIX_W-1:0]   req_cr_sample      = '0;
   logic [PIX_W-1:0]   req_luma_odd       = '0;
   logic               rsp_valid;
   logic               rsp_ready          = 1'b0;
   logic [COUNT_W-1:0] rsp_total_count;
   logic [COUNT_W-1:0] rsp_left_count;
   logic [COUNT_W-1:0] rsp_center_count;
   logic [COUNT_W-1:0] rsp_right_count;
   logic               csr_wr_en          = 1'b0;
   logic [2:0]         csr_index          = '0;
   logic [CSR_W-1:0]   csr_wdata          = '0;

   yuv_range_zone_pixel_count #(
      .STRIP_COUNT     (STRIPS),
      .STRIP_THICKNESS (STRIP_WIDTH),
      .STRIP_GAP       (STRIP_SPACING)
   ) u_dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_start_of_frame (req_start_of_frame),
      .req_cb_sample      (req_cb_sample),
      .req_luma_even      (req_luma_even),
      .req_cr_sample      (req_cr_sample),
      .req_luma_odd       (req_luma_odd),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_total_count    (rsp_total_count),
      .rsp_left_count     (rsp_left_count),
      .rsp_center_count   (rsp_center_count),
      .rsp_right_count    (rsp_right_count),
      .csr_wr_en          (csr_wr_en),
      .csr_index          (csr_index),
      .csr_wdata          (csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Register shadow, at reset values
   logic [PIX_W-1:0] luma_lo = 8'd0;
   logic [PIX_W-1:0] luma_hi = 8'd255;
   logic [PIX_W-1:0] cb_lo   = 8'd0;
   logic [PIX_W-1:0] cb_hi   = 8'd255;
   logic [PIX_W-1:0] cr_lo   = 8'd0;
   logic [PIX_W-1:0] cr_hi   = 8'd255;
   logic [WP_W-1:0]  width_reg  = 12'd120;
   logic [HT_W-1:0]  height_reg = 13'd240;

   // Raster position and running tallies of the frame in progress
   logic [COL_W-1:0] col_pos = '0;
   logic [ROW_W-1:0] row_pos = '0;
   counts_type       tally   = '0;

   counts_type     frame_results[$];
   script_row_type script[$];

   int  failures     = 0;
   int  results_seen = 0;
   int  pairs_sent   = 0;
   int  csr_writes   = 0;
   int  holds_done   = 0;
   bit  hold_pending = 1'b0;
   bit  req_burst    = 1'b0;
   bit  rsp_burst    = 1'b0;

   function automatic int eff_width();
      if (width_reg == 0) return 1;
      if (width_reg > yrzpc_pkg::MAX_WIDTH_PAIRS) return int'(yrzpc_pkg::MAX_WIDTH_PAIRS);
      return int'(width_reg);
   endfunction

   function automatic int eff_height();
      if (height_reg == 0) return 1;
      if (height_reg > yrzpc_pkg::MAX_HEIGHT) return int'(yrzpc_pkg::MAX_HEIGHT);
      return int'(height_reg);
   endfunction

   function automatic bit strip_column(input int x, input int scan_w);
      int block;
      int span;
      int offset;
      int start;
      int stop;
      int i;
      block  = STRIP_WIDTH + STRIP_SPACING;
      span   = block * STRIPS - STRIP_SPACING;
      offset = (scan_w > span) ? (scan_w - span) / 2 : 0;
      for (i = 0; i < STRIPS; i++) begin
         start = offset + i * block;
         stop  = start + STRIP_WIDTH;
         if (start >= scan_w) continue;
         if (stop > scan_w) stop = scan_w;
         if (x >= start && x < stop) return 1'b1;
      end
      return 1'b0;
   endfunction

   function automatic logic [COUNT_W-1:0] bump(input logic [COUNT_W-1:0] v);
      return (v == yrzpc_pkg::COUNT_MAX) ? v : v + 1'b1;
   endfunction

   task automatic clear_frame();
      col_pos = '0;
      row_pos = '0;
      tally   = '0;
   endtask

   task automatic tally_pixel(input int x, input logic [PIX_W-1:0] y, u, v,
                              input int scan_w, input int h);
      if (!strip_column(x, scan_w)) return;
      if (y < luma_lo || y > luma_hi) return;
      if (u < cb_lo || u > cb_hi) return;
      if (v < cr_lo || v > cr_hi) return;
      tally.total = bump(tally.total);
      if (row_pos < (h * 3) / 10)
         tally.left_zone = bump(tally.left_zone);
      if (row_pos >= h / 4 && row_pos < (h * 3) / 4)
         tally.center_zone = bump(tally.center_zone);
      if (row_pos >= (h * 7) / 10)
         tally.right_zone = bump(tally.right_zone);
   endtask

   task automatic predict_pair(input pair_type p, output bit emits,
                               output counts_type result);
      int w;
      int h;
      w      = eff_width();
      h      = eff_height();
      emits  = 1'b0;
      result = '0;
      if (p.sof) clear_frame();
      // clamp a position left past the end by a size change
      if (col_pos >= w) col_pos = COL_W'(w - 1);
      if (row_pos >= h) row_pos = ROW_W'(h - 1);
      tally_pixel(2 * col_pos, p.y_even, p.cb, p.cr, 2 * w, h);
      tally_pixel(2 * col_pos + 1, p.y_odd, p.cb, p.cr, 2 * w, h);
      if (col_pos + 1 >= w && row_pos + 1 >= h) begin
         emits  = 1'b1;
         result = tally;
         clear_frame();
      end else if (col_pos + 1 >= w) begin
         col_pos = '0;
         row_pos = row_pos + 1'b1;
      end else begin
         col_pos = col_pos + 1'b1;
      end
   endtask

   function automatic script_row_type pair_row(input bit sof, input logic [PIX_W-1:0] cb,
                                               y0, cr, y1);
      script_row_type r;
      r.kind   = ROW_PAIR;
      r.idx    = yrzpc_pkg::CSR_LUMA_LOW;
      r.value  = '0;
      r.pair   = '{sof, cb, y0, cr, y1};
      r.typed  = 1'b0;
      r.counts = '0;
      return r;
   endfunction

   function automatic script_row_type typed_row(input bit sof, input logic [PIX_W-1:0] cb,
                                                y0, cr, y1, input int t, l, c, rt);
      script_row_type r;
      r        = pair_row(sof, cb, y0, cr, y1);
      r.typed  = 1'b1;
      r.counts = '{COUNT_W'(t), COUNT_W'(l), COUNT_W'(c), COUNT_W'(rt)};
      return r;
   endfunction

   function automatic script_row_type csr_row(input yrzpc_pkg::csr_index_type idx,
                                              input logic [CSR_W-1:0] value);
      script_row_type r;
      r       = pair_row(1'b0, '0, '0, '0, '0);
      r.kind  = ROW_CSR;
      r.idx   = idx;
      r.value = value;
      return r;
   endfunction

   task automatic send_pair(input pair_type p, input bit fixed,
                            input counts_type fixed_counts);
      int         gap;
      bit         emits;
      counts_type predicted;
      gap = req_burst ? 0 : $urandom_range(0, MAX_GAP);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_start_of_frame <= p.sof;
      req_cb_sample      <= p.cb;
      req_luma_even      <= p.y_even;
      req_cr_sample      <= p.cr;
      req_luma_odd       <= p.y_odd;
      req_valid          <= 1'b1;
      do @(posedge clock); while (!req_ready);
      predict_pair(p, emits, predicted);
      if (fixed)
         frame_results.push_back(fixed_counts);
      else if (emits)
         frame_results.push_back(predicted);
      pairs_sent++;
   endtask

   // Drop valid, let every pending frame result arrive, then let the pipe drain
   task automatic drain_and_idle();
      req_valid <= 1'b0;
      while (frame_results.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_csr(input yrzpc_pkg::csr_index_type idx,
                            input logic [CSR_W-1:0] value);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      case (idx)
         yrzpc_pkg::CSR_LUMA_LOW:  luma_lo    = value[PIX_W-1:0];
         yrzpc_pkg::CSR_LUMA_HIGH: luma_hi    = value[PIX_W-1:0];
         yrzpc_pkg::CSR_CB_LOW:    cb_lo      = value[PIX_W-1:0];
         yrzpc_pkg::CSR_CB_HIGH:   cb_hi      = value[PIX_W-1:0];
         yrzpc_pkg::CSR_CR_LOW:    cr_lo      = value[PIX_W-1:0];
         yrzpc_pkg::CSR_CR_HIGH:   cr_hi      = value[PIX_W-1:0];
         yrzpc_pkg::CSR_WIDTH:     width_reg  = value[WP_W-1:0];
         yrzpc_pkg::CSR_HEIGHT:    height_reg = value[HT_W-1:0];
         default: ;
      endcase
      csr_writes++;
      @(posedge clock);
   endtask

   task automatic program_all(input logic [PIX_W-1:0] yl, yh, ul, uh, vl, vh,
                              input logic [WP_W-1:0] wp, input logic [HT_W-1:0] ht);
      drain_and_idle();
      write_csr(yrzpc_pkg::CSR_LUMA_LOW, CSR_W'(yl));
      write_csr(yrzpc_pkg::CSR_LUMA_HIGH, CSR_W'(yh));
      write_csr(yrzpc_pkg::CSR_CB_LOW, CSR_W'(ul));
      write_csr(yrzpc_pkg::CSR_CB_HIGH, CSR_W'(uh));
      write_csr(yrzpc_pkg::CSR_CR_LOW, CSR_W'(vl));
      write_csr(yrzpc_pkg::CSR_CR_HIGH, CSR_W'(vh));
      write_csr(yrzpc_pkg::CSR_WIDTH, CSR_W'(wp));
      write_csr(yrzpc_pkg::CSR_HEIGHT, CSR_W'(ht));
   endtask

   task automatic draw_range(output logic [PIX_W-1:0] lo, hi);
      case ($urandom_range(0, 9))
         0: begin
            lo = 8'd0;
            hi = 8'd255;
         end
         1: begin
            hi = 8'($urandom_range(0, 254));
            lo = 8'($urandom_range(hi + 1, 255));
         end
         2: begin
            lo = 8'($urandom);
            hi = lo;
         end
         default: begin
            lo = 8'($urandom_range(0, 127));
            hi = 8'($urandom_range(128, 255));
         end
      endcase
   endtask

   task automatic program_random(input logic [WP_W-1:0] wp, input logic [HT_W-1:0] ht);
      logic [PIX_W-1:0] yl, yh, ul, uh, vl, vh;
      draw_range(yl, yh);
      draw_range(ul, uh);
      draw_range(vl, vh);
      program_all(yl, yh, ul, uh, vl, vh, wp, ht);
   endtask

   // Open a frame at a size that clamps, then shrink to one pair so the next pair closes it
   task automatic send_clamped(input logic [WP_W-1:0] wp, input logic [HT_W-1:0] ht);
      int       i;
      pair_type p;
      program_random(wp, ht);
      for (i = 0; i < CLAMP_PAIRS; i++) begin
         p = '{i == 0, 8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom)};
         send_pair(p, 1'b0, '0);
      end
      drain_and_idle();
      write_csr(yrzpc_pkg::CSR_WIDTH, 13'd1);
      write_csr(yrzpc_pkg::CSR_HEIGHT, 13'd1);
      p = '{1'b0, 8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom)};
      send_pair(p, 1'b0, '0);
   endtask

   // Mostly clean frames; allow_breaks adds cut-short frames and stray marks
   task automatic send_random_frames(input int frames, input bit allow_breaks);
      int       f;
      int       i;
      int       n;
      pair_type p;
      for (f = 0; f < frames; f++) begin
         n = eff_width() * eff_height();
         if (allow_breaks && $urandom_range(0, 9) == 0) n = $urandom_range(1, n);
         for (i = 0; i < n; i++) begin
            if (pairs_sent >= PAIR_BUDGET) return;
            if (i == 0)
               p.sof = allow_breaks ? ($urandom_range(0, 7) != 0) : 1'b1;
            else
               p.sof = allow_breaks && ($urandom_range(0, 59) == 0);
            p.cb     = 8'($urandom);
            p.y_even = 8'($urandom);
            p.cr     = 8'($urandom);
            p.y_odd  = 8'($urandom);
            send_pair(p, 1'b0, '0);
         end
      end
   endtask

   task automatic check_field(input string name, input logic [COUNT_W-1:0] want, got);
      if (got !== want) begin
         $error("%s: expected %0d, actual %0d", name, want, got);
         failures++;
      end
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (frame_results.size() == 0) begin
            $error("frame result with none pending: total_count %0d", rsp_total_count);
            failures++;
         end else begin
            check_field("total_count", frame_results[0].total, rsp_total_count);
            check_field("left_count", frame_results[0].left_zone, rsp_left_count);
            check_field("center_count", frame_results[0].center_zone, rsp_center_count);
            check_field("right_count", frame_results[0].right_zone, rsp_right_count);
            void'(frame_results.pop_front());
         end
         results_seen++;
      end
   end

   initial begin : response_sink
      int gap;
      @(negedge reset);
      forever begin
         if (hold_pending) begin
            // hold off long enough for the block to back up into the request side
            hold_pending = 1'b0;
            rsp_ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
            holds_done++;
         end
         gap = rsp_burst ? 0 : $urandom_range(0, MAX_GAP);
         if (gap > 0) begin
            rsp_ready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!rsp_valid);
      end
   end

   initial begin : run_limit
      #10_000_000;
      $display("yuv_range_zone_pixel_count_test: FAIL");
      $finish;
   end

   initial begin : stimulus
      int       k;
      int       i;
      pair_type p;
      logic [WP_W-1:0] wp;
      logic [HT_W-1:0] ht;

      // Reset values: no frame completes in the first few pairs
      script.push_back(pair_row(1'b1, 8'h00, 8'h00, 8'h00, 8'h00));
      script.push_back(pair_row(1'b0, 8'hFF, 8'hFF, 8'hFF, 8'hFF));
      script.push_back(pair_row(1'b0, 8'h5A, 8'hA5, 8'h3C, 8'hC3));
      // Shrink mid-frame to one pair: every pair ends a frame, only x=0 sampled
      script.push_back(csr_row(yrzpc_pkg::CSR_WIDTH, 13'd1));
      script.push_back(csr_row(yrzpc_pkg::CSR_HEIGHT, 13'd1));
      script.push_back(typed_row(1'b0, 8'h00, 8'h00, 8'h00, 8'h00, 1, 0, 0, 1));
      script.push_back(typed_row(1'b1, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 1, 0, 0, 1));
      // Inverted luma range matches nothing
      script.push_back(csr_row(yrzpc_pkg::CSR_LUMA_LOW, 13'd200));
      script.push_back(csr_row(yrzpc_pkg::CSR_LUMA_HIGH, 13'd100));
      script.push_back(typed_row(1'b0, 8'h80, 8'h80, 8'h80, 8'h80, 0, 0, 0, 0));
      // Single-value luma range; odd pixel is outside the strips here
      script.push_back(csr_row(yrzpc_pkg::CSR_LUMA_LOW, 13'd128));
      script.push_back(csr_row(yrzpc_pkg::CSR_LUMA_HIGH, 13'd128));
      script.push_back(typed_row(1'b0, 8'h80, 8'd128, 8'h80, 8'd0, 1, 0, 0, 1));
      script.push_back(typed_row(1'b0, 8'h80, 8'd127, 8'h80, 8'd128, 0, 0, 0, 0));
      script.push_back(typed_row(1'b0, 8'h80, 8'd129, 8'h80, 8'd128, 0, 0, 0, 0));
      // Blue chroma bounds are inclusive
      script.push_back(csr_row(yrzpc_pkg::CSR_LUMA_LOW, 13'd0));
      script.push_back(csr_row(yrzpc_pkg::CSR_LUMA_HIGH, 13'd255));
      script.push_back(csr_row(yrzpc_pkg::CSR_CB_LOW, 13'd10));
      script.push_back(csr_row(yrzpc_pkg::CSR_CB_HIGH, 13'd20));
      script.push_back(typed_row(1'b0, 8'd10, 8'h40, 8'h80, 8'h40, 1, 0, 0, 1));
      script.push_back(typed_row(1'b0, 8'd20, 8'h40, 8'h80, 8'h40, 1, 0, 0, 1));
      script.push_back(typed_row(1'b0, 8'd9, 8'h40, 8'h80, 8'h40, 0, 0, 0, 0));
      script.push_back(typed_row(1'b0, 8'd21, 8'h40, 8'h80, 8'h40, 0, 0, 0, 0));
      // Red chroma pinned to the top code
      script.push_back(csr_row(yrzpc_pkg::CSR_CB_LOW, 13'd0));
      script.push_back(csr_row(yrzpc_pkg::CSR_CB_HIGH, 13'd255));
      script.push_back(csr_row(yrzpc_pkg::CSR_CR_LOW, 13'd255));
      script.push_back(csr_row(yrzpc_pkg::CSR_CR_HIGH, 13'd255));
      script.push_back(typed_row(1'b0, 8'h80, 8'h40, 8'd255, 8'h40, 1, 0, 0, 1));
      script.push_back(typed_row(1'b0, 8'h80, 8'h40, 8'd254, 8'h40, 0, 0, 0, 0));
      // Two by four frame: each row lands in a different mix of zones
      script.push_back(csr_row(yrzpc_pkg::CSR_CR_LOW, 13'd0));
      script.push_back(csr_row(yrzpc_pkg::CSR_CR_HIGH, 13'd255));
      script.push_back(csr_row(yrzpc_pkg::CSR_WIDTH, 13'd2));
      script.push_back(csr_row(yrzpc_pkg::CSR_HEIGHT, 13'd4));
      for (i = 0; i < 8; i++)
         script.push_back(pair_row(i == 0, 8'(i * 31), 8'(i * 17), 8'(255 - i * 29),
                                   8'(i * 53)));

      repeat (2) @(posedge clock);
      reset <= 1'b0;

      for (k = 0; k < script.size(); k++) begin
         if (script[k].kind == ROW_CSR) begin
            drain_and_idle();
            write_csr(script[k].idx, script[k].value);
         end else begin
            send_pair(script[k].pair, script[k].typed, script[k].counts);
         end
      end

      // Size extremes, including out-of-range values that clamp
      req_burst = 1'b1;
      rsp_burst = ($urandom_range(0, 1) == 1);
      send_clamped(12'd4095, 13'd1);
      send_clamped(12'd0, 13'd8191);
      send_clamped(12'd2048, 13'd0);

      // One-pair frames back to back against a stalled receiver
      program_all(8'd0, 8'd255, 8'd0, 8'd255, 8'd0, 8'd255, 12'd1, 13'd1);
      rsp_burst    = 1'b0;
      hold_pending = 1'b1;
      for (i = 0; i < 40; i++) begin
         p = '{1'b0, 8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom)};
         send_pair(p, 1'b0, '0);
      end

      while (pairs_sent < PAIR_BUDGET) begin
         k = $urandom_range(0, 9);
         if (k < 7) begin
            wp = 12'($urandom_range(1, 8));
            ht = 13'($urandom_range(0, 6));
         end else if (k < 9) begin
            wp = 12'($urandom_range(33, 70));
            ht = 13'($urandom_range(1, 3));
         end else begin
            wp = 12'd0;
            ht = 13'($urandom_range(0, 12));
         end
         req_burst = ($urandom_range(0, 3) == 0);
         rsp_burst = ($urandom_range(0, 3) == 0);
         program_random(wp, ht);
         send_random_frames($urandom_range(1, 3), 1'b1);
      end

      req_valid <= 1'b0;
      rsp_burst = 1'b1;
      while (frame_results.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);

      $display("Sent %0d pixel pair requests and checked %0d frame results", pairs_sent,
               results_seen);
      $display("Made %0d register writes; long receiver stalls: %0d", csr_writes, holds_done);
      if (failures == 0)
         $display("yuv_range_zone_pixel_count_test: PASS");
      else
         $display("yuv_range_zone_pixel_count_test: FAIL");
      $finish;
   end

endmodule

// File: filelist.f
sv/yrzpc_pkg.sv
sv/yuv_range_zone_pixel_count.sv
bench/yuv_range_zone_pixel_count_test.sv
